// ----- rtl/gtg_pkg.sv -----
`timescale 1ns / 1ps

package gtg_pkg;

    // Field widths
    localparam int COORD_W = 16;   // Q8.8 positions and targets
    localparam int DIFF_W  = 17;   // target minus position
    localparam int HEAD_W  = 15;   // Q3.12 heading
    localparam int GAIN_W  = 16;   // Q4.12 gain
    localparam int SPEED_W = 15;   // Q7.8 speed
    localparam int TURN_W  = 13;   // Q1.12 turn rate

    // Internal widths
    localparam int SQ_W    = 34;   // squared distance and root accumulator
    localparam int DIST_W  = 17;   // integer square root of the squared distance
    localparam int XY_W    = 44;   // CORDIC vector components
    localparam int ANG_W   = 20;   // CORDIC angle, Q.16 radians
    localparam int ERR_W   = 22;   // heading error before wrapping
    localparam int AERR_W  = 21;   // magnitude of the wrapped error
    localparam int PROD_W  = 33;   // gain times distance
    localparam int XY_SHIFT = 24;  // vector scaling before rotation

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN   = 24;
    localparam int SQRT_STEPS = 17;

    // Angles in Q.16 radians
    localparam int ANG_PI      = 205887;
    localparam int ANG_TWO_PI  = 411775;
    localparam int ANG_HALF_PI = 102944;
    localparam int TURN_THRESH = 13108;
    localparam int TURN_ROUND  = 16;
    localparam int TURN_SHIFT  = 5;
    localparam int TURN_MAX    = 6434;
    localparam int ARRIVE_SQ   = 164;
    localparam int GAIN_SHIFT  = 12;

    // Register reset values
    localparam logic signed [COORD_W-1:0] TARGET_X_RST = 16'sd768;
    localparam logic signed [COORD_W-1:0] TARGET_Y_RST = 16'sd1024;
    localparam logic [GAIN_W-1:0]         GAIN_RST     = 16'd4096;
    localparam logic [SPEED_W-1:0]        LIMIT_RST    = 15'd768;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_X    = 2'd0,
        REG_TARGET_Y    = 2'd1,
        REG_SPEED_GAIN  = 2'd2,
        REG_SPEED_LIMIT = 2'd3
    } cfg_reg_t;

    // Data handed from one cell of the chain to the next
    typedef struct packed {
        logic                     arrive_n;  // high while the target is still away
        logic signed [HEAD_W-1:0] hd;
        logic signed [XY_W-1:0]   x;
        logic signed [XY_W-1:0]   y;
        logic signed [ANG_W-1:0]  z;
        logic [SQ_W-1:0]          n;         // remainder of the square root
        logic [SQ_W-1:0]          r;         // partial root
    } gtg_cell_t;

    // round(atan(2^-i) * 65536)
    function automatic int atan_q16(input int idx);
        int v;
        case (idx)
            0:  v = 51472;
            1:  v = 30386;
            2:  v = 16055;
            3:  v = 8150;
            4:  v = 4091;
            5:  v = 2047;
            6:  v = 1024;
            7:  v = 512;
            8:  v = 256;
            9:  v = 128;
            10: v = 64;
            11: v = 32;
            12: v = 16;
            13: v = 8;
            14: v = 4;
            15: v = 2;
            16: v = 1;
            default: v = 0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/gtg_front.sv -----
`timescale 1ns / 1ps

module gtg_front
    import gtg_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic signed [HEAD_W-1:0]  heading,
    input  logic signed [COORD_W-1:0] target_x,
    input  logic signed [COORD_W-1:0] target_y,
    output logic                      out_valid,
    output gtg_cell_t                 out_data
);

    localparam logic signed [ANG_W-1:0] HALF_PI_A = ANG_W'(ANG_HALF_PI);
    localparam logic [SQ_W-1:0]         ARRIVE_A  = SQ_W'(ARRIVE_SQ);

    // Stage A: offsets to the target
    logic                     va_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic signed [HEAD_W-1:0] hda_reg;

    // Stage B: squares and the quadrant pre-rotation
    logic                     vb_reg;
    logic [SQ_W-1:0]          dxsq_reg, dysq_reg;
    logic signed [XY_W-1:0]   xb_reg, yb_reg;
    logic signed [ANG_W-1:0]  zb_reg;
    logic signed [HEAD_W-1:0] hdb_reg;

    logic                     vc_reg;
    gtg_cell_t                c_reg;

    logic signed [SQ_W-1:0]   dxsq_full, dysq_full;
    logic signed [XY_W-1:0]   x0, y0, xb_next, yb_next;
    logic signed [ANG_W-1:0]  zb_next;
    logic [SQ_W-1:0]          sq_sum;

    assign dxsq_full = SQ_W'(dx_reg) * SQ_W'(dx_reg);
    assign dysq_full = SQ_W'(dy_reg) * SQ_W'(dy_reg);
    assign x0 = XY_W'(dx_reg) <<< XY_SHIFT;
    assign y0 = XY_W'(dy_reg) <<< XY_SHIFT;
    assign sq_sum = dxsq_reg + dysq_reg;

    always_comb begin
        xb_next = x0;
        yb_next = y0;
        zb_next = '0;
        if (dx_reg[DIFF_W-1]) begin
            if (!dy_reg[DIFF_W-1]) begin
                xb_next = y0;
                yb_next = -x0;
                zb_next = HALF_PI_A;
            end else begin
                xb_next = -y0;
                yb_next = x0;
                zb_next = -HALF_PI_A;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg   <= DIFF_W'(target_x) - DIFF_W'(pos_x);
            dy_reg   <= DIFF_W'(target_y) - DIFF_W'(pos_y);
            hda_reg  <= heading;
            dxsq_reg <= $unsigned(dxsq_full);
            dysq_reg <= $unsigned(dysq_full);
            xb_reg   <= xb_next;
            yb_reg   <= yb_next;
            zb_reg   <= zb_next;
            hdb_reg  <= hda_reg;
            c_reg.arrive_n <= (sq_sum >= ARRIVE_A);
            c_reg.hd <= hdb_reg;
            c_reg.x  <= xb_reg;
            c_reg.y  <= yb_reg;
            c_reg.z  <= zb_reg;
            c_reg.n  <= sq_sum;
            c_reg.r  <= '0;
        end
    end

    assign out_valid = vc_reg;
    assign out_data  = c_reg;

endmodule

// ----- rtl/gtg_cell.sv -----
`timescale 1ns / 1ps

module gtg_cell
    import gtg_pkg::*;
#(
    parameter int IDX    = 0,
    parameter bit ROT_EN = 1'b1
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  gtg_cell_t in_data,
    output logic      out_valid,
    output gtg_cell_t out_data
);

    // Each cell does a CORDIC rotation if ROT_EN, a root digit if SQRT_EN.
    localparam bit SQRT_EN  = (IDX < SQRT_STEPS);
    localparam int SQ_SHIFT = SQRT_EN ? 2 * (SQRT_STEPS - 1 - IDX) : 0;
    localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << SQ_SHIFT;
    localparam logic signed [ANG_W-1:0] ATAN_STEP = ANG_W'(atan_q16(IDX));

    logic                   valid_reg;
    gtg_cell_t              data_reg;
    gtg_cell_t              data_next;
    logic signed [XY_W-1:0] xin, yin, xs, ys;
    logic [SQ_W:0]          trial;

    assign xin   = in_data.x;
    assign yin   = in_data.y;
    assign xs    = xin >>> IDX;
    assign ys    = yin >>> IDX;
    assign trial = {1'b0, in_data.r} + {1'b0, SQ_BIT};

    always_comb begin
        data_next = in_data;
        if (ROT_EN) begin
            if (!yin[XY_W-1]) begin
                data_next.x = xin + ys;
                data_next.y = yin - xs;
                data_next.z = in_data.z + ATAN_STEP;
            end else begin
                data_next.x = xin - ys;
                data_next.y = yin + xs;
                data_next.z = in_data.z - ATAN_STEP;
            end
        end
        if (SQRT_EN) begin
            if ({1'b0, in_data.n} >= trial) begin
                data_next.n = in_data.n - trial[SQ_W-1:0];
                data_next.r = (in_data.r >> 1) + SQ_BIT;
            end else begin
                data_next.r = in_data.r >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/gtg_back.sv -----
`timescale 1ns / 1ps

module gtg_back
    import gtg_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic                      in_arrive_n,
    input  logic signed [HEAD_W-1:0]  in_hd,
    input  logic signed [ANG_W-1:0]   in_z,
    input  logic [DIST_W-1:0]         in_dist,
    input  logic [GAIN_W-1:0]         speed_gain,
    input  logic [SPEED_W-1:0]        speed_limit,
    output logic                      res_valid,
    output logic [SPEED_W-1:0]        res_speed,
    output logic [TURN_W-1:0]         res_turn
);

    localparam logic signed [ERR_W-1:0] PI_E     = ERR_W'(ANG_PI);
    localparam logic signed [ERR_W-1:0] TWO_PI_E = ERR_W'(ANG_TWO_PI);
    localparam logic [AERR_W-1:0]       THRESH_E = AERR_W'(TURN_THRESH);
    localparam logic [AERR_W:0]         ROUND_E  = (AERR_W + 1)'(TURN_ROUND);
    localparam int                      TQ_W     = AERR_W + 1 - TURN_SHIFT;
    localparam logic [TQ_W-1:0]         TMAX_E   = TQ_W'(TURN_MAX);
    localparam int                      SF_W     = PROD_W - GAIN_SHIFT;

    // Stage 1: raw error and the speed product
    logic                    v1_reg, arr1_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic [PROD_W-1:0]       prod_reg;

    // Stage 2: wrapped error magnitude and the clamped speed
    logic                    v2_reg, arr2_reg;
    logic [AERR_W-1:0]       aerr_reg;
    logic [SPEED_W-1:0]      speed_reg;

    logic signed [ERR_W-1:0] err_next, err_wrap, err_abs;
    logic [SF_W-1:0]         speed_full;
    logic [SPEED_W-1:0]      speed_next;
    logic [AERR_W:0]         turn_sum;
    logic [TQ_W-1:0]         turn_q;
    logic [TURN_W-1:0]       turn_sat;

    assign err_next = ERR_W'(in_z) - (ERR_W'(in_hd) <<< 4);

    always_comb begin
        if (err_reg > PI_E) begin
            err_wrap = err_reg - TWO_PI_E;
        end else if (err_reg < -PI_E) begin
            err_wrap = err_reg + TWO_PI_E;
        end else begin
            err_wrap = err_reg;
        end
        err_abs = err_wrap[ERR_W-1] ? -err_wrap : err_wrap;
    end

    assign speed_full = prod_reg[PROD_W-1:GAIN_SHIFT];
    assign speed_next = (speed_full > SF_W'(speed_limit)) ? speed_limit
                                                          : speed_full[SPEED_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            arr1_reg  <= in_arrive_n;
            err_reg   <= err_next;
            prod_reg  <= PROD_W'(speed_gain) * PROD_W'(in_dist);
            arr2_reg  <= arr1_reg;
            aerr_reg  <= AERR_W'($unsigned(err_abs));
            speed_reg <= speed_next;
        end
    end

    // Half the error magnitude, rounded, saturated at a quarter turn.
    assign turn_sum = {1'b0, aerr_reg} + ROUND_E;
    assign turn_q   = turn_sum[AERR_W:TURN_SHIFT];
    assign turn_sat = (turn_q > TMAX_E) ? TMAX_E[TURN_W-1:0] : turn_q[TURN_W-1:0];

    always_comb begin
        res_speed = '0;
        res_turn  = '0;
        if (arr2_reg) begin
            if (aerr_reg >= THRESH_E) begin
                res_turn = turn_sat;
            end else begin
                res_speed = speed_reg;
            end
        end
    end

    assign res_valid = v2_reg;

endmodule

// ----- rtl/go_to_goal_steering_core.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_pos_x, s_pos_y, s_heading
// m_        out        m_valid / m_ready   m_forward_speed, m_turn_rate
// cfg_      in         cfg_wr_en           cfg_index, cfg_wdata
//
// One request is taken per clock while s_ready is high; each request passes
// through the front stages, the cell chain and the back stages to the output
// register, which drives m_valid. Reset is synchronous and active low; it
// empties the pipeline and restores the configuration registers. A stalled
// result is held in the output register, and a second one in the skid register;
// only with both full does s_ready fall and the whole pipeline freeze.

module go_to_goal_steering_core
    import gtg_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_pos_x,
    input  logic signed [COORD_W-1:0] s_pos_y,
    input  logic signed [HEAD_W-1:0]  s_heading,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [SPEED_W-1:0]        m_forward_speed,
    output logic [TURN_W-1:0]         m_turn_rate,

    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

    // The chain is long enough for both the rotations and the seventeen
    // digits of the square root; surplus cells only carry their data along.
    localparam int N_CELLS = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

    // Configuration registers. Writes must arrive only while the block is idle;
    // the block does not enforce this, and every stage reads them directly.
    logic signed [COORD_W-1:0] target_x_reg, target_y_reg;
    logic [GAIN_W-1:0]         speed_gain_reg;
    logic [SPEED_W-1:0]        speed_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_x_reg    <= TARGET_X_RST;
            target_y_reg    <= TARGET_Y_RST;
            speed_gain_reg  <= GAIN_RST;
            speed_limit_reg <= LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TARGET_X:    target_x_reg    <= $signed(cfg_wdata);
                REG_TARGET_Y:    target_y_reg    <= $signed(cfg_wdata);
                REG_SPEED_GAIN:  speed_gain_reg  <= cfg_wdata;
                REG_SPEED_LIMIT: speed_limit_reg <= cfg_wdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together whenever the skid register is free.
    logic pipe_en;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;

    logic      cell_valid [N_CELLS+1];
    gtg_cell_t cell_data  [N_CELLS+1];

    // Offsets, squared distance and the quadrant pre-rotation.
    gtg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_valid),
        .pos_x     (s_pos_x),
        .pos_y     (s_pos_y),
        .heading   (s_heading),
        .target_x  (target_x_reg),
        .target_y  (target_y_reg),
        .out_valid (cell_valid[0]),
        .out_data  (cell_data[0])
    );

    // Each cell performs, where enabled, one CORDIC micro-rotation towards the x
    // axis and settles one bit of the integer square root, then hands on.
    for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
        gtg_cell #(
            .IDX    (i),
            .ROT_EN ((i < CORDIC_STAGES) && (i < ATAN_LEN))
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (cell_valid[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    // Heading error, wrapping, and the choice between turning and driving.
    logic                res_valid;
    logic [SPEED_W-1:0]  res_speed;
    logic [TURN_W-1:0]   res_turn;

    gtg_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (pipe_en),
        .in_valid    (cell_valid[N_CELLS]),
        .in_arrive_n (cell_data[N_CELLS].arrive_n),
        .in_hd       (cell_data[N_CELLS].hd),
        .in_z        (cell_data[N_CELLS].z),
        .in_dist     (cell_data[N_CELLS].r[DIST_W-1:0]),
        .speed_gain  (speed_gain_reg),
        .speed_limit (speed_limit_reg),
        .res_valid   (res_valid),
        .res_speed   (res_speed),
        .res_turn    (res_turn)
    );

    // Output register with a skid register behind it. When the output is
    // blocked, the result leaving the pipeline is parked in the skid register,
    // which then stops the pipeline until the output frees up again.
    logic [SPEED_W-1:0] out_speed_reg, skid_speed_reg;
    logic [TURN_W-1:0]  out_turn_reg,  skid_turn_reg;
    logic               out_free;

    assign out_free = m_ready || !out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= res_valid;
            end
        end else if (res_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_speed_reg <= skid_speed_reg;
                out_turn_reg  <= skid_turn_reg;
            end else begin
                out_speed_reg <= res_speed;
                out_turn_reg  <= res_turn;
            end
        end else if (!skid_valid_reg) begin
            skid_speed_reg <= res_speed;
            skid_turn_reg  <= res_turn;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_forward_speed = out_speed_reg;
    assign m_turn_rate     = out_turn_reg;

endmodule

// ----- tb/sv/gtg_steer_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the steering core and the register port. Every
// accepted request gets its expected command worked out on the spot; every
// accepted result is compared with the oldest command still outstanding.
module gtg_steer_checker
    import gtg_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_pos_x,
    input  logic signed [COORD_W-1:0] s_pos_y,
    input  logic signed [HEAD_W-1:0]  s_heading,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [SPEED_W-1:0]        m_forward_speed,
    input  logic [TURN_W-1:0]         m_turn_rate,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    output int                        n_errors,
    output int                        n_pending
);

    // Angles are in Q.16 radians, squared distances in Q16.16.
    localparam longint NEAR_SQ      = 164;
    localparam longint PI_Q16       = 205887;
    localparam longint TWO_PI_Q16   = 411775;
    localparam longint HALF_PI_Q16  = 102944;
    localparam longint TURN_MIN_ERR = 13108;
    localparam longint TURN_CAP     = 6434;
    localparam longint VEC_SCALE    = 64'sd16777216;
    localparam int     ROT_DEPTH    = 24;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [TURN_W-1:0]  turn;
    } steer_cmd_t;

    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic [15:0]        gain_q12;
    logic [14:0]        speed_cap;

    steer_cmd_t cmd_fifo[$];
    longint     atan_q16_tab[ROT_DEPTH];
    int         n_results;

    // The arctangent table is derived here from first principles rather than
    // taken from the design, so a wrong entry there shows up as a mismatch.
    initial begin
        n_errors  = 0;
        n_pending = 0;
        n_results = 0;
        for (int i = 0; i < ROT_DEPTH; i++) begin
            atan_q16_tab[i] = longint'($rtoi($atan(1.0 / (2.0 ** i)) * 65536.0 + 0.5));
        end
    end

    task automatic report_mismatch(input string msg);
        $display("steer check @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // Vectoring rotation of (dx, dy) towards the positive x axis; the angle
    // swept is the bearing of the goal.
    function automatic longint goal_bearing(input longint dx, input longint dy);
        longint vx;
        longint vy;
        longint ang;
        longint sx;
        longint sy;
        longint t;
        vx  = dx * VEC_SCALE;
        vy  = dy * VEC_SCALE;
        ang = 0;
        if (vx < 0) begin
            if (vy >= 0) begin
                t = vx; vx = vy; vy = -t; ang = HALF_PI_Q16;
            end else begin
                t = vx; vx = -vy; vy = t; ang = -HALF_PI_Q16;
            end
        end
        for (int i = 0; i < CORDIC_STAGES && i < ROT_DEPTH; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy >= 0) begin
                vx = vx + sy; vy = vy - sx; ang = ang + atan_q16_tab[i];
            end else begin
                vx = vx - sy; vy = vy + sx; ang = ang - atan_q16_tab[i];
            end
        end
        return ang;
    endfunction

    function automatic longint floor_root(input longint n);
        longint r;
        longint c;
        r = 0;
        for (int b = 17; b >= 0; b--) begin
            c = r | (64'sd1 <<< b);
            if (c * c <= n) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic steer_cmd_t predict_command(input logic signed [15:0] px,
                                                   input logic signed [15:0] py,
                                                   input logic signed [14:0] hd);
        steer_cmd_t cmd;
        longint     dx;
        longint     dy;
        longint     sq;
        longint     err;
        longint     aerr;
        longint     spd;
        longint     trn;
        dx  = longint'(goal_x) - longint'(px);
        dy  = longint'(goal_y) - longint'(py);
        sq  = dx * dx + dy * dy;
        spd = 0;
        trn = 0;
        if (sq >= NEAR_SQ) begin
            err = goal_bearing(dx, dy) - longint'(hd) * 16;
            if (err > PI_Q16) begin
                err = err - TWO_PI_Q16;
            end else if (err < -PI_Q16) begin
                err = err + TWO_PI_Q16;
            end
            aerr = (err < 0) ? -err : err;
            if (aerr >= TURN_MIN_ERR) begin
                trn = (aerr + 16) >> 5;
                if (trn > TURN_CAP) begin
                    trn = TURN_CAP;
                end
            end else begin
                spd = (longint'(gain_q12) * floor_root(sq)) >> 12;
                if (spd > longint'(speed_cap)) begin
                    spd = longint'(speed_cap);
                end
            end
        end
        cmd.speed = spd[SPEED_W-1:0];
        cmd.turn  = trn[TURN_W-1:0];
        return cmd;
    endfunction

    always @(posedge aclk) begin : watch
        steer_cmd_t want;
        if (!aresetn) begin
            cmd_fifo.delete();
            goal_x    = 16'sd768;
            goal_y    = 16'sd1024;
            gain_q12  = 16'd4096;
            speed_cap = 15'd768;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TARGET_X:    goal_x    = cfg_wdata;
                    REG_TARGET_Y:    goal_y    = cfg_wdata;
                    REG_SPEED_GAIN:  gain_q12  = cfg_wdata;
                    REG_SPEED_LIMIT: speed_cap = cfg_wdata[14:0];
                    default: ;
                endcase
            end
            // Retire before queuing, so a result never meets its own request.
            if (m_valid && m_ready) begin
                if (cmd_fifo.size() == 0) begin
                    report_mismatch($sformatf("unrequested result speed=%0d turn=%0d",
                                              m_forward_speed, m_turn_rate));
                end else begin
                    want = cmd_fifo.pop_front();
                    if (m_forward_speed !== want.speed) begin
                        report_mismatch($sformatf("result %0d forward_speed %0d, wanted %0d",
                                                  n_results, m_forward_speed, want.speed));
                    end
                    if (m_turn_rate !== want.turn) begin
                        report_mismatch($sformatf("result %0d turn_rate %0d, wanted %0d",
                                                  n_results, m_turn_rate, want.turn));
                    end
                end
                n_results++;
            end
            if (s_valid && s_ready) begin
                cmd_fifo.push_back(predict_command(s_pos_x, s_pos_y, s_heading));
            end
        end
        n_pending = cmd_fifo.size();
    end

endmodule

// ----- tb/sv/tb_go_to_goal_steering_core.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the go-to-goal steering core. The checker beside
// the block does all prediction and comparison; this module only makes
// requests, paces the result side and decides how the run ends.
module tb_go_to_goal_steering_core;
    import gtg_pkg::*;

    localparam int STAGES      = CORDIC_STAGES_DEF;
    localparam int PHASES      = 6;
    localparam int PER_PHASE   = 325;      // random requests in each register setting
    localparam int LONG_HOLD   = 150;      // cycles the receiver refuses results
    localparam int STALL_LIMIT = 3000;     // cycles with no handshake before giving up
    localparam int TAIL_CYCLES = 40;       // idle cycles after the last result is home

    typedef enum int {
        POSE_ALIGNED,   // heading close to the bearing, so the core mostly drives
        POSE_NEAR,      // around the goal, where the arrival test decides
        POSE_ANY        // every bit of every field at random
    } pose_kind_t;

    logic                      aclk;
    logic                      aresetn         = 1'b0;
    logic                      s_valid         = 1'b0;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_pos_x         = '0;
    logic signed [COORD_W-1:0] s_pos_y         = '0;
    logic signed [HEAD_W-1:0]  s_heading       = '0;
    logic                      m_valid;
    logic                      m_ready         = 1'b0;
    logic [SPEED_W-1:0]        m_forward_speed;
    logic [TURN_W-1:0]         m_turn_rate;
    logic                      cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index       = '0;
    logic [CFG_DATA_W-1:0]     cfg_wdata       = '0;

    int n_errors;
    int n_pending;

    // Pacing knobs, written only by the stimulus process.
    int send_idle_pct = 9;
    int recv_idle_pct = 46;
    int hold_requests = 0;

    // The goal currently programmed, kept so that random poses can be aimed.
    int aim_x = 768;
    int aim_y = 1024;

    int quiet_cycles = 0;

    go_to_goal_steering_core #(
        .CORDIC_STAGES(STAGES)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_heading      (s_heading),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_forward_speed(m_forward_speed),
        .m_turn_rate    (m_turn_rate),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    gtg_steer_checker #(
        .CORDIC_STAGES(STAGES)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_heading      (s_heading),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_forward_speed(m_forward_speed),
        .m_turn_rate    (m_turn_rate),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .n_errors       (n_errors),
        .n_pending      (n_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Result side. Normally m_ready is drawn afresh every cycle; when the
    // stimulus asks for a long hold-off, this process counts it out itself so
    // that the sender is free to keep offering requests meanwhile. The core
    // then fills its pipeline and skid register and has to drop s_ready.
    initial begin : result_side
        int served;
        served = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (served != hold_requests) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                served++;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Any cycle in which neither channel moves a request or a result counts
    // towards the limit; a lost result therefore ends the run here.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_go_to_goal_steering_core: errors");
                $finish;
            end
        end
    end

    // Offers one request and returns at the edge where it is taken. Idle
    // cycles are inserted beforehand with valid low, never while a request
    // is on offer, so the payload is stable for as long as valid is high.
    task automatic send_pose(input int px, input int py, input int hd);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_pos_x   <= px[15:0];
        s_pos_y   <= py[15:0];
        s_heading <= hd[14:0];
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // Stops offering and waits until every outstanding request has produced
    // its result. Each request yields exactly one result, so nothing can still
    // be in flight once the checker has nothing outstanding.
    task automatic settle_pipeline();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (n_pending != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic put_reg(input cfg_reg_t idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic program_regs(input int tx, input int ty, input int gain, input int lim);
        put_reg(REG_TARGET_X, tx[15:0]);
        put_reg(REG_TARGET_Y, ty[15:0]);
        put_reg(REG_SPEED_GAIN, gain[15:0]);
        put_reg(REG_SPEED_LIMIT, lim[15:0]);
        cfg_wr_en <= 1'b0;
        aim_x = tx;
        aim_y = ty;
    endtask

    initial begin : stimulus
        int         rand_count;
        int         span;
        int         ox;
        int         oy;
        int         px;
        int         py;
        int         hd;
        pose_kind_t kind;
        int         pick;

        rand_count = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests against the reset goal of (3.0, 4.0).
        send_pose(768, 1024, 0);          // exactly on the goal: arrived
        send_pose(759, 1015, 0);          // squared distance just under the threshold
        send_pose(758, 1016, 0);          // just over it, facing away: turn
        send_pose(758, 1016, 2763);       // just over it, facing the goal: crawl
        send_pose(0, 0, 0);               // goal off to the left: turn
        send_pose(0, 0, 3798);            // facing the goal: speed clamped to the limit
        send_pose(1024, 1024, 0);         // goal right behind: largest turn rate
        send_pose(1024, 1024, 12868);     // goal behind, heading at plus pi
        send_pose(1024, 1024, -12868);    // goal behind, heading at minus pi: wraps
        send_pose(512, 1024, 0);          // straight along plus x
        send_pose(768, 768, 6434);        // straight along plus y
        send_pose(768, 1280, -6434);      // straight along minus y
        send_pose(-32768, -32768, 12868);
        send_pose(32767, 32767, -12868);
        send_pose(32767, -32768, -16384); // heading beyond minus pi
        send_pose(-32768, 32767, 16383);  // heading beyond plus pi
        send_pose(1024, 1025, -16384);    // goal behind with an out-of-range heading
        send_pose(0, 1024, 16383);

        for (int phase = 0; phase < PHASES; phase++) begin
            // Registers change only with the pipeline empty.
            if (phase > 0) begin
                settle_pipeline();
                case (phase)
                    1: program_regs(0, 0, 4096, 32767);
                    2: program_regs(-32768, 32767, 65535, 65535);
                    3: program_regs(32767, -32768, 0, 0);
                    4: program_regs(int'($urandom_range(0, 65535)) - 32768,
                                    int'($urandom_range(0, 65535)) - 32768,
                                    $urandom_range(0, 65535), $urandom_range(0, 32767));
                    default: program_regs(-100, 200, 16384, 12000);
                endcase
            end

            for (int k = 0; k < PER_PHASE; k++) begin
                // First the sender idles rarely and the receiver often, then the
                // other way round, and in the last stretch neither idles.
                if (rand_count == 2 * PER_PHASE) begin
                    send_idle_pct = 46;
                    recv_idle_pct = 9;
                end else if (rand_count == 4 * PER_PHASE) begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end

                // Back-pressure: the receiver refuses results for a long while
                // as requests keep coming, so the core has to stall its input.
                if (phase == 1 && k == 100) begin
                    hold_requests++;
                end
                // And once the sender holds back until all results are home.
                if (phase == 2 && k == 150) begin
                    settle_pipeline();
                end

                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    kind = POSE_ALIGNED;
                end else if (pick < 55) begin
                    kind = POSE_NEAR;
                end else begin
                    kind = POSE_ANY;
                end

                case (kind)
                    POSE_ALIGNED: begin
                        // Mostly short hops so the speed is not always clamped.
                        case ($urandom_range(0, 3))
                            0:       span = 64;
                            1:       span = 1024;
                            2:       span = 8192;
                            default: span = 32768;
                        endcase
                        ox = int'($urandom_range(0, 2 * span)) - span;
                        oy = int'($urandom_range(0, 2 * span)) - span;
                        px = (((aim_x - ox) + 32768) & 65535) - 32768;
                        py = (((aim_y - oy) + 32768) & 65535) - 32768;
                        // Just under 0.2 rad of jitter either side stays inside the
                        // turn threshold, so the core drives rather than turns here.
                        hd = $rtoi($atan2(real'(aim_y - py), real'(aim_x - px)) * 4096.0)
                             + int'($urandom_range(0, 1600)) - 800;
                    end
                    POSE_NEAR: begin
                        px = (((aim_x + int'($urandom_range(0, 24)) - 12) + 32768) & 65535)
                             - 32768;
                        py = (((aim_y + int'($urandom_range(0, 24)) - 12) + 32768) & 65535)
                             - 32768;
                        hd = int'($urandom_range(0, 32767)) - 16384;
                    end
                    default: begin
                        px = int'($urandom_range(0, 65535)) - 32768;
                        py = int'($urandom_range(0, 65535)) - 32768;
                        hd = int'($urandom_range(0, 32767)) - 16384;
                    end
                endcase

                send_pose(px, py, hd);
                rand_count++;
            end
        end

        settle_pipeline();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (n_errors == 0 && n_pending == 0) begin
            $display("tb_go_to_goal_steering_core: clean");
        end else begin
            $display("tb_go_to_goal_steering_core: errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/gtg_pkg.sv
rtl/gtg_front.sv
rtl/gtg_cell.sv
rtl/gtg_back.sv
rtl/go_to_goal_steering_core.sv
tb/sv/gtg_steer_checker.sv
tb/sv/tb_go_to_goal_steering_core.sv
